// ===== hdl/sorted_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_defines: assertion macros
// Shared concurrent assertion forms for the sorted priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// condition must hold on every edge out of reset
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes
// Capacity, result status codes, op codes and the cell/command structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;

  // beat op codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // contents of one cell
  typedef struct packed {
    logic               vld;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } cell_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               ins_en;
    logic               rem_en;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor, on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::cmd_t  cmd,
  input  spq_pkg::cell_t left_cell,
  input  logic           left_ins,
  input  spq_pkg::cell_t right_cell,
  output logic           ins_o,
  output spq_pkg::cell_t cell_o
);

  spq_pkg::cell_t cell_r;
  spq_pkg::cell_t cell_nxt;
  logic           gt;

  // new entry belongs at or before this slot
  assign gt    = cell_r.vld && (cell_r.prio > cmd.prio);
  assign ins_o = !cell_r.vld || gt;

  // next contents
  always_comb begin
    cell_nxt = cell_r;
    if (cmd.ins_en) begin
      if (left_ins) begin
        cell_nxt = left_cell;
      end else if (ins_o) begin
        cell_nxt.vld   = 1'b1;
        cell_nxt.value = cmd.value;
        cell_nxt.prio  = cmd.prio;
      end
    end else if (cmd.rem_en) begin
      cell_nxt = right_cell;
    end
  end

  // valid bit cleared on reset, payload left as is
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_nxt.vld;
    end
    cell_r.value <= cell_nxt.value;
    cell_r.prio  <= cell_nxt.prio;
  end

  assign cell_o = cell_r;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept as a sorted cell chain
// Result of an accepted beat lands in the output register in the next cycle.
// One beat per cycle unless stalled by out_ready; cells compare and shift in parallel.
// Reset: synchronous active-low rst_n clears all cell valid bits (empty queue)
// and the output valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic signed [31:0] in_item_value,
  input  logic signed [15:0] in_priority_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_item_out,
  output logic signed [15:0] out_priority_out
);

  localparam int N = spq_pkg::CAPACITY;

  spq_pkg::cell_t cells [N];
  logic [N-1:0]   ins;
  spq_pkg::cmd_t  cmd;
  logic           accept;
  logic           full;
  logic           empty;

  logic               out_valid_r,  out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic signed [31:0] out_item_r,   out_item_nxt;
  logic signed [15:0] out_prio_r,   out_prio_nxt;

  // accept while the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = cells[N-1].vld;
  assign empty    = !cells[0].vld;

  // command broadcast
  always_comb begin
    cmd.ins_en = accept && (in_mode == spq_pkg::MODE_INSERT) && !full;
    cmd.rem_en = accept && (in_mode == spq_pkg::MODE_REMOVE) && !empty;
    cmd.value  = in_item_value;
    cmd.prio   = in_priority_req;
  end

  // cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::cell_t left_c;
    spq_pkg::cell_t right_c;
    logic           left_i;
    if (i == 0) begin : g_head
      assign left_c = '0;
      assign left_i = 1'b0;
    end else begin : g_body
      assign left_c = cells[i-1];
      assign left_i = ins[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_next
      assign right_c = cells[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_cell  (left_c),
      .left_ins   (left_i),
      .right_cell (right_c),
      .ins_o      (ins[i]),
      .cell_o     (cells[i])
    );
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_prio_nxt   = out_prio_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '0;
      out_prio_nxt  = '0;
      if (in_mode == spq_pkg::MODE_INSERT) begin
        out_status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end else if (empty) begin
        out_status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        out_status_nxt = spq_pkg::ST_REMOVED;
        out_item_nxt   = cells[0].value;
        out_prio_nxt   = cells[0].prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_prio_r   <= out_prio_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_item_out     = out_item_r;
  assign out_priority_out = out_prio_r;

  // the two head cells are packed and in priority order
  `SPQ_ASSERT_ALWAYS(a_head_sorted, !cells[1].vld || (cells[0].vld && cells[0].prio <= cells[1].prio), "head cells out of order")
  // a remove on a non-empty queue returns the old head
  `SPQ_ASSERT_NEXT(a_remove_head, accept && in_mode == spq_pkg::MODE_REMOVE && !empty, out_status == spq_pkg::ST_REMOVED && out_item_out == $past(cells[0].value), "remove did not return head")
  // a dropped insert reports full and leaves the queue full with its head value unchanged
  `SPQ_ASSERT_NEXT(a_full_drop, accept && in_mode == spq_pkg::MODE_INSERT && full, out_status == spq_pkg::ST_FULL && cells[N-1].vld && $stable(cells[0].value), "full insert changed queue")

endmodule

// ===== dv/tb_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// Drives insert and remove beats with bursty input traffic and a patterned
// result stall. A scoreboard keeps a sorted copy of the queue, predicts the
// result of every accepted beat and checks result beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  // one predicted result beat
  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } spq_result_t;

  // sorted shadow of the queue plus the expected result fifo
  class pq_scoreboard;
    logic signed [31:0] stored_value [spq_pkg::CAPACITY];
    logic signed [15:0] stored_prio [spq_pkg::CAPACITY];
    int unsigned        depth;
    spq_result_t        pending_results [$];
    int unsigned        mismatches;
    int unsigned        n_insert, n_remove, n_full, n_empty, n_checked, peak_depth;

    function void record_request(logic mode, logic signed [31:0] value,
                                 logic signed [15:0] prio);
      spq_result_t exp;
      int          pos;
      int          i;
      exp.status = spq_pkg::ST_INSERTED;
      exp.value  = '0;
      exp.prio   = '0;
      if (mode == spq_pkg::MODE_INSERT) begin
        if (depth >= spq_pkg::CAPACITY) begin
          exp.status = spq_pkg::ST_FULL;
          n_full++;
        end else begin
          // new entry goes before the first strictly larger priority
          pos = depth;
          for (i = 0; i < depth; i++)
            if (pos == depth && stored_prio[i] > prio) pos = i;
          for (i = depth; i > pos; i--) begin
            stored_value[i] = stored_value[i-1];
            stored_prio[i]  = stored_prio[i-1];
          end
          stored_value[pos] = value;
          stored_prio[pos]  = prio;
          depth++;
          if (depth > peak_depth) peak_depth = depth;
          n_insert++;
        end
      end else begin
        if (depth == 0) begin
          exp.status = spq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          // pop the front and close the gap
          exp.status = spq_pkg::ST_REMOVED;
          exp.value  = stored_value[0];
          exp.prio   = stored_prio[0];
          for (i = 1; i < depth; i++) begin
            stored_value[i-1] = stored_value[i];
            stored_prio[i-1]  = stored_prio[i];
          end
          depth--;
          n_remove++;
        end
      end
      pending_results.push_back(exp);
    endfunction

    function void check_response(logic [1:0] status, logic signed [31:0] value,
                                 logic signed [15:0] prio);
      spq_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d value=%0d prio=%0d",
                 $time, status, value, prio);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      n_checked++;
      if (status !== exp.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, exp.status, status);
        mismatches++;
      end
      if (value !== exp.value) begin
        $display("%0t: item_out mismatch expected %0d actual %0d", $time, exp.value, value);
        mismatches++;
      end
      if (prio !== exp.prio) begin
        $display("%0t: priority_out mismatch expected %0d actual %0d",
                 $time, exp.prio, prio);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_mode = spq_pkg::MODE_INSERT;
  logic signed [31:0] in_item_value = '0;
  logic signed [15:0] in_priority_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_item_out;
  logic signed [15:0] out_priority_out;

  int unsigned  cycle_count = 0;
  int unsigned  stall_tick = 0;
  pq_scoreboard sb = new();

  sorted_priority_queue DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_item_value    (in_item_value),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_item_out     (out_item_out),
    .out_priority_out (out_priority_out)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // result stall pattern: free flow, light random, periodic, heavy random
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (stall_tick[2:0] == 3'd0);
      default: out_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // beat monitor: note accepted inputs, then check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.record_request(in_mode, in_item_value, in_priority_req);
      if (out_valid && out_ready)
        sb.check_response(out_status, out_item_out, out_priority_out);
    end
  end

  // hold one input beat until it is accepted
  task automatic drive_beat(input logic mode, input logic signed [31:0] value,
                            input logic signed [15:0] prio);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_item_value   <= value;
    in_priority_req <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // idle the input with junk on the payload
  task automatic pause_sender(input int cycles);
    int n;
    for (n = 0; n < cycles; n++) begin
      in_valid        <= 1'b0;
      in_mode         <= 1'($urandom_range(0, 1));
      in_item_value   <= $urandom;
      in_priority_req <= 16'($urandom);
      @(posedge clk);
    end
  endtask

  // hold off until every expected result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly clustered priorities for ties, sometimes full range or extremes
  function automatic logic signed [15:0] pick_priority();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 16'(int'($urandom_range(0, 6)) - 3);
    if (sel < 8) return 16'($urandom);
    if (sel == 8) return 16'sh7fff;
    return 16'sh8000;
  endfunction

  initial begin
    int          i;
    int          sent;
    int          burst;
    int          insert_pct;
    bit          drained_mid;
    logic        mode;

    sent        = 0;
    drained_mid = 1'b0;

    // reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: remove on empty queue
    drive_beat(spq_pkg::MODE_REMOVE, 32'sd0, 16'sd0);
    // directed: field extremes, zero, all ones
    drive_beat(spq_pkg::MODE_INSERT, 32'sh7fffffff, 16'sh7fff);
    drive_beat(spq_pkg::MODE_INSERT, 32'sh80000000, 16'sh8000);
    drive_beat(spq_pkg::MODE_INSERT, 32'sd0, 16'sd0);
    drive_beat(spq_pkg::MODE_INSERT, -32'sd1, -16'sd1);
    // directed: equal priorities keep arrival order
    drive_beat(spq_pkg::MODE_INSERT, 32'sd5, 16'sd3);
    drive_beat(spq_pkg::MODE_INSERT, 32'sd6, 16'sd3);
    drive_beat(spq_pkg::MODE_INSERT, 32'sd7, 16'sd3);
    // fill up to capacity
    for (i = 0; i < spq_pkg::CAPACITY - 7; i++)
      drive_beat(spq_pkg::MODE_INSERT, 32'(i * 32'h01010101), 16'(100 - 20 * i));
    // insert into a full queue is dropped
    drive_beat(spq_pkg::MODE_INSERT, 32'sh12345678, -16'sd5);
    drive_beat(spq_pkg::MODE_REMOVE, 32'sh0badf00d, 16'sh1234);
    // tie at the tail of the queue
    drive_beat(spq_pkg::MODE_INSERT, 32'sh5a5a5a5a, 16'sh7fff);
    drive_beat(spq_pkg::MODE_INSERT, 32'sh0f0f0f0f, 16'sh7fff);
    drive_beat(spq_pkg::MODE_REMOVE, 32'sd0, 16'sd0);
    drive_beat(spq_pkg::MODE_REMOVE, 32'sd0, 16'sd0);
    wait_for_drain();

    // random: bursts with alternating fill and drain bias
    insert_pct = 85;
    while (sent < RANDOM_ITEMS) begin
      if ((sent / 48) % 4 == 0) insert_pct = 85;
      else if ((sent / 48) % 4 == 1) insert_pct = 15;
      else if ((sent / 48) % 4 == 2) insert_pct = 50;
      else insert_pct = 95;
      burst = $urandom_range(1, 24);
      for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        mode = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::MODE_INSERT
                                                     : spq_pkg::MODE_REMOVE;
        drive_beat(mode, $urandom, pick_priority());
        sent++;
      end
      if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        drained_mid = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 6));
      end
    end

    // wind down
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d removes, %0d full drops, %0d empty removes",
             sb.n_insert, sb.n_remove, sb.n_full, sb.n_empty);
    $display("peak depth %0d of %0d, %0d result beats checked, %0d mismatches",
             sb.peak_depth, spq_pkg::CAPACITY, sb.n_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
